// ===== design/frpgd_pkg.sv =====
// Package of types and constants shared by the feed record parser and gap detector.
`default_nettype none
package frpgd_pkg;

    localparam int RECORD_BYTES = 17;
    localparam int POS_W        = 5;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-3:0] REG_FIRST_SEQUENCE = '0;
    localparam logic [DATA_W-1:0] FIRST_SEQUENCE_RESET = 32'd1;

    typedef struct packed {
        logic [7:0] feed_byte;
        logic       buffer_start;
    } in_t;

    typedef struct packed {
        logic        [31:0] symbol;
        logic        [7:0]  side;
        logic signed [31:0] quantity;
        logic signed [31:0] price;
        logic signed [31:0] sequence_res;
        logic signed [31:0] gap_first;
        logic        [31:0] gap_count;
        logic               stale;
    } out_t;

    typedef struct packed {
        logic        [31:0] symbol;
        logic        [7:0]  side;
        logic signed [31:0] quantity;
        logic signed [31:0] price;
        logic signed [31:0] sequence_num;
    } record_t;

    typedef struct packed {
        logic              load;
        logic [DATA_W-1:0] value;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/frpgd_regs.sv =====
// Configuration register bank holding the first expected sequence number.
`default_nettype none
module frpgd_regs
    import frpgd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [DATA_W-1:0] first_seq_reg;
    logic              wr_first;

    assign pready   = 1'b1;
    assign wr_first = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_FIRST_SEQUENCE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_seq_reg <= FIRST_SEQUENCE_RESET;
        end else if (wr_first) begin
            first_seq_reg <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_FIRST_SEQUENCE: prdata = first_seq_reg;
            default:            prdata = '0;
        endcase
    end

    assign cfg.load  = wr_first;
    assign cfg.value = pwdata;

endmodule
`default_nettype wire

// ===== design/frpgd_framer.sv =====
// Byte framer that gathers feed bytes into complete records.
`default_nettype none
module frpgd_framer
    import frpgd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic byte_valid,
    input  wire in_t  byte_in,
    output logic      byte_ready,
    output logic      rec_valid,
    output record_t   rec,
    input  wire logic rec_take
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_eff;
    logic [127:0]     shift_reg;
    logic [127:0]     shift_next;
    logic             rec_valid_reg;
    logic             rec_valid_next;
    record_t          rec_reg;
    record_t          rec_next;
    logic             byte_fire;
    logic             last_byte;
    logic [135:0]     full_rec;

    assign byte_ready = !rec_valid_reg || rec_take;
    assign byte_fire  = byte_valid && byte_ready;
    assign pos_eff    = byte_in.buffer_start ? '0 : pos_reg;
    assign last_byte  = (pos_eff == LAST_POS);
    assign full_rec   = {shift_reg, byte_in.feed_byte};

    always_comb begin
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        rec_valid_next = rec_valid_reg && !rec_take;
        rec_next       = rec_reg;
        if (byte_fire) begin
            if (last_byte) begin
                pos_next              = '0;
                rec_valid_next        = 1'b1;
                rec_next.symbol       = full_rec[135:104];
                rec_next.side         = full_rec[103:96];
                rec_next.quantity     = full_rec[95:64];
                rec_next.price        = full_rec[63:32];
                rec_next.sequence_num = full_rec[31:0];
            end else begin
                pos_next   = pos_eff + POS_W'(1);
                shift_next = {shift_reg[119:0], byte_in.feed_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rec_reg   <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("framer position beyond the last record byte");

endmodule
`default_nettype wire

// ===== design/frpgd_checker.sv =====
// Sequence checker that detects gaps and stale records and holds the result register.
`default_nettype none
module frpgd_checker
    import frpgd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire logic    rec_valid,
    input  wire record_t rec,
    output logic         rec_take,
    output logic         out_valid,
    output out_t         out_data,
    input  wire logic    out_ready
);

    logic [31:0] exp_reg;
    logic [31:0] exp_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_t        out_reg;
    out_t        out_next;
    logic        stale_c;
    logic        gap_c;

    assign rec_take = rec_valid && (!out_valid_reg || out_ready);
    assign stale_c  = $signed(rec.sequence_num) < $signed(exp_reg);
    assign gap_c    = $signed(rec.sequence_num) > $signed(exp_reg);

    always_comb begin
        exp_next       = exp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (cfg.load) begin
            exp_next = cfg.value;
        end
        if (rec_take) begin
            out_valid_next        = 1'b1;
            out_next.symbol       = rec.symbol;
            out_next.side         = rec.side;
            out_next.quantity     = rec.quantity;
            out_next.price        = rec.price;
            out_next.sequence_res = rec.sequence_num;
            out_next.stale        = stale_c;
            out_next.gap_first    = gap_c ? $signed(exp_reg) : '0;
            out_next.gap_count    = gap_c ? (rec.sequence_num - exp_reg) : '0;
            if (!stale_c) begin
                exp_next = rec.sequence_num + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg       <= FIRST_SEQUENCE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            exp_reg       <= exp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_stale_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.stale |-> (out_reg.gap_count == '0) && (out_reg.gap_first == '0))
        else $error("stale record reported with a gap");

    a_gap_span: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.gap_count != '0) |->
            (out_reg.sequence_res - out_reg.gap_first) == out_reg.gap_count)
        else $error("gap count does not match the missing run");

    a_expected_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_take && !stale_c && !cfg.load |=> exp_reg == $past(rec.sequence_num) + 32'd1)
        else $error("expected sequence not advanced past the accepted record");

endmodule
`default_nettype wire

// ===== design/feed_record_parser_gap_detect.sv =====
// Top level of the market feed record parser with sequence gap detection.
//
// Feed bytes arrive on the s_ channel, one transfer per byte, with buffer_start
// marking the first byte of a new buffer; a partial record is then dropped.
// Every 17 bytes form a record, and the last byte of a record yields one
// transfer on the m_ channel with the decoded fields and the sequence check.
// The block accepts one byte every clock cycle while s_ready is high. The result
// becomes valid once the record register has passed the completed record to the
// result register, and then transfers when m_ready is high.
// When the receiver stalls, the result register holds and the framer keeps
// taking bytes until a second completed record has to wait in the record
// register, at which point s_ready falls.
// The APB port holds first_sequence at address 0; writing it also loads the
// expected sequence number and must only be done while the block is idle.
// Reset clears the framing position and both valid flags, and sets the first
// and expected sequence numbers to 1.
`default_nettype none
module feed_record_parser_gap_detect
    import frpgd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_payload,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t    cfg;
    record_t rec;
    logic    rec_valid;
    logic    rec_take;

    frpgd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    frpgd_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_valid),
        .byte_in    (s_payload),
        .byte_ready (s_ready),
        .rec_valid  (rec_valid),
        .rec        (rec),
        .rec_take   (rec_take)
    );

    frpgd_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_take  (rec_take),
        .out_valid (m_valid),
        .out_data  (m_payload),
        .out_ready (m_ready)
    );

endmodule
`default_nettype wire
